// File: hw/rtl/tdsr_pkg.sv
// Shared types, codes and sizing constants for the table-driven slot reservation.
package tdsr_pkg;

  localparam int TABLE_SLOTS_DEF = 8;
  localparam int MAX_CLIENTS_DEF = 15;
  localparam int TIME_W = 64;
  localparam int CNT_W = 7;

  localparam logic [2:0] FN_LOAD     = 3'd0;
  localparam logic [2:0] FN_ARRIVE   = 3'd1;
  localparam logic [2:0] FN_DEPART   = 3'd2;
  localparam logic [2:0] FN_REFILL   = 3'd3;
  localparam logic [2:0] FN_DRAIN    = 3'd4;
  localparam logic [2:0] FN_DISPATCH = 3'd5;

  localparam logic [1:0] PH_INACTIVE = 2'd0;
  localparam logic [1:0] PH_ACTIVE   = 2'd1;
  localparam logic [1:0] PH_DEPLETED = 2'd2;
  localparam logic [1:0] PH_IDLE     = 2'd3;

  localparam logic [1:0] REG_CYCLE_LEN = 2'd0;
  localparam logic [1:0] REG_ORIGIN    = 2'd1;
  localparam logic [1:0] REG_SLOTS     = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] now_time;
    logic [2:0]  slot_number;
    logic [63:0] slot_begin;
    logic [63:0] slot_finish;
    logic [63:0] drain_amount;
  } evt_t;

  typedef struct packed {
    logic [1:0]  resv_state;
    logic [63:0] budget_left;
    logic [63:0] next_refill_time;
    logic [63:0] consumed_in_slot;
    logic [63:0] consumed_total;
    logic        grant;
    logic        fault;
  } res_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] rem;
  } div_stat_t;

endpackage

// File: hw/rtl/table_driven_slot_reservation.sv
// Top level of the table-driven slot reservation scheduler.
//
//   Channel   Handshake              Payload
//   evt       evt_valid / evt_stall  evt  (evt_t, one scheduler event)
//   res       res_valid / res_stall  res  (res_t, one result per event)
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every event walks a fixed sequencer: a slot table read, a capture, a
// cursor wrap step, a second table read and capture, an optional wait on
// the remainder unit and the execute state. The block takes no new event
// until the last one has left the execute state.
// Every event, whatever its kind, stays in the cursor wrap step while it
// subtracts the slot count: once when the cursor sits on the last slot in
// use, more often after the slot count has been lowered, else not at all.
// An arrival that opens the reservation with a nonzero cycle length waits
// in the wait state until the serial remainder unit is done.
// Reset is synchronous and clears all scheduler state; the slot table is
// not cleared and must be loaded before use.
// A stalled result sits in the output register; the next event is already
// taken meanwhile and waits in its execute cycle until that register frees.
module table_driven_slot_reservation
  import tdsr_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  evt_t        evt,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CCW = $clog2(MAX_CLIENTS + 1);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_CAP1 = 8'b0000_0100,
    S_MOD  = 8'b0000_1000,
    S_RD2  = 8'b0001_0000,
    S_CAP2 = 8'b0010_0000,
    S_DIVW = 8'b0100_0000,
    S_EXEC = 8'b1000_0000
  } seq_t;

  seq_t st;

  // Configuration registers.
  logic [63:0] cycle_len;
  logic [63:0] origin;
  logic [3:0]  slots_cfg;

  // Scheduler state.
  logic [1:0]     phase;
  logic [CCW-1:0] client_count;
  logic [63:0]    cycle_base;
  logic [SW-1:0]  cursor;
  logic [63:0]    win_start;
  logic [63:0]    win_end;
  logic [63:0]    budget;
  logic [63:0]    used_slot;
  logic [63:0]    used_total;
  logic [63:0]    refill;

  // Item being worked on and the table words read for it.
  evt_t        cur;
  logic [63:0] a_begin;
  logic [63:0] a_end;
  logic [63:0] b_begin;
  logic [63:0] arr_base;
  logic [CNT_W-1:0] nxt;

  // Slot table memory: begin offset in the upper half, end in the lower.
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [127:0]  ram_wdata;
  logic [SW-1:0] ram_raddr;
  logic [127:0]  ram_rdata;

  tdsr_ram #(
    .WIDTH(128),
    .DEPTH(TABLE_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The remainder unit runs only for an arrival that opens the reservation.
  logic      div_start;
  logic      opens;
  div_stat_t div_stat;

  assign opens     = (cur.func == FN_ARRIVE) && (phase == PH_INACTIVE) &&
                     (client_count < CCW'(MAX_CLIENTS));
  assign div_start = (st == S_READ) && opens && (cycle_len != 64'd0);

  tdsr_rem #(
    .W(TIME_W)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(cur.now_time - origin),
    .divisor (cycle_len),
    .stat    (div_stat)
  );

  // Effective slot count, clamped into one through TABLE_SLOTS.
  logic [CNT_W-1:0] eff;
  logic [CNT_W-1:0] slots_ext;

  assign slots_ext = CNT_W'(slots_cfg);
  always_comb begin
    if (slots_ext == '0) begin
      eff = CNT_W'(1);
    end else if (slots_ext > CNT_W'(TABLE_SLOTS)) begin
      eff = CNT_W'(TABLE_SLOTS);
    end else begin
      eff = slots_ext;
    end
  end

  logic [CNT_W-1:0] sn_ext;
  assign sn_ext = CNT_W'(cur.slot_number);

  always_comb begin
    unique case (st)
      S_READ:  ram_raddr = (cur.func == FN_ARRIVE) ? '0 : cursor;
      S_RD2:   ram_raddr = nxt[SW-1:0];
      default: ram_raddr = cursor;
    endcase
  end

  logic out_free;
  assign out_free = !res_valid || !res_stall;

  assign ram_we    = (st == S_EXEC) && out_free && (cur.func == FN_LOAD) &&
                     (sn_ext < CNT_W'(TABLE_SLOTS));
  assign ram_waddr = sn_ext[SW-1:0];
  assign ram_wdata = {cur.slot_begin, cur.slot_finish};

  assign evt_stall = (st != S_IDLE);
  assign cfg_ready = 1'b1;

  // Execute-cycle next values of the scheduler state.
  logic [1:0]     phase_next;
  logic [CCW-1:0] client_count_next;
  logic [63:0]    cycle_base_next;
  logic [SW-1:0]  cursor_next;
  logic [63:0]    win_start_next;
  logic [63:0]    win_end_next;
  logic [63:0]    budget_next;
  logic [63:0]    used_slot_next;
  logic [63:0]    used_total_next;
  logic [63:0]    refill_next;
  logic           grant;
  logic           fault;
  logic [63:0]    new_start;
  logic [63:0]    new_end;
  logic [63:0]    left_cur;
  logic [63:0]    left_new;
  logic [63:0]    base_adv;

  assign new_start = cycle_base + a_begin;
  assign new_end   = cycle_base + a_end;
  assign left_cur  = (cur.now_time >= win_end) ? 64'd0 : win_end - cur.now_time;
  assign left_new  = (cur.now_time >= new_end) ? 64'd0 : new_end - cur.now_time;
  assign base_adv  = (nxt == '0) ? cycle_base + cycle_len : cycle_base;

  always_comb begin
    phase_next        = phase;
    client_count_next = client_count;
    cycle_base_next   = cycle_base;
    cursor_next       = cursor;
    win_start_next    = win_start;
    win_end_next      = win_end;
    budget_next       = budget;
    used_slot_next    = used_slot;
    used_total_next   = used_total;
    refill_next       = refill;
    grant             = 1'b0;
    fault             = 1'b0;
    case (cur.func)
      FN_LOAD: begin
      end
      FN_ARRIVE: begin
        if (client_count >= CCW'(MAX_CLIENTS)) begin
          fault = 1'b1;
        end else begin
          client_count_next = client_count + 1'b1;
          if (phase == PH_INACTIVE) begin
            cycle_base_next = arr_base;
            cursor_next     = '0;
            refill_next     = arr_base + a_begin;
            phase_next      = PH_DEPLETED;
          end else if (phase == PH_IDLE) begin
            phase_next = PH_ACTIVE;
          end
        end
      end
      FN_DEPART: begin
        if (phase == PH_INACTIVE || phase == PH_IDLE || client_count == '0) begin
          fault = 1'b1;
        end else begin
          client_count_next = client_count - 1'b1;
          if (phase == PH_ACTIVE && client_count == CCW'(1)) begin
            phase_next = PH_IDLE;
          end
        end
      end
      FN_REFILL: begin
        if (phase == PH_INACTIVE) begin
          fault = 1'b1;
        end else begin
          win_start_next  = new_start;
          win_end_next    = new_end;
          budget_next     = left_new;
          used_slot_next  = '0;
          cursor_next     = nxt[SW-1:0];
          cycle_base_next = base_adv;
          refill_next     = base_adv + b_begin;
          phase_next      = (client_count != '0) ? PH_ACTIVE : PH_IDLE;
        end
      end
      FN_DRAIN: begin
        if (phase == PH_INACTIVE || phase == PH_DEPLETED ||
            win_start > cur.now_time) begin
          fault = 1'b1;
        end else begin
          used_slot_next  = used_slot + cur.drain_amount;
          used_total_next = used_total + cur.drain_amount;
          budget_next     = left_cur;
          if (left_cur == '0) begin
            phase_next = PH_DEPLETED;
          end
        end
      end
      FN_DISPATCH: begin
        if (phase == PH_INACTIVE) begin
          fault = 1'b1;
        end else begin
          budget_next = left_cur;
          if (left_cur == '0) begin
            phase_next = PH_DEPLETED;
          end else begin
            grant = (client_count != '0);
          end
        end
      end
      default: begin
        fault = 1'b1;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      unique case (st)
        S_IDLE: if (evt_valid) st <= S_READ;
        S_READ: st <= S_CAP1;
        S_CAP1: st <= S_MOD;
        S_MOD:  if (nxt < eff) st <= S_RD2;
        S_RD2:  st <= S_CAP2;
        S_CAP2: st <= S_DIVW;
        S_DIVW: if (!div_stat.busy) st <= S_EXEC;
        S_EXEC: if (out_free) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // Item and table data registers.
  always_ff @(posedge clk) begin
    if (st == S_IDLE && evt_valid) begin
      cur <= evt;
    end
    if (st == S_READ) begin
      nxt <= CNT_W'(cursor) + 1'b1;
    end else if (st == S_MOD && nxt >= eff) begin
      nxt <= nxt - eff;
    end
    if (st == S_CAP1) begin
      a_begin <= ram_rdata[127:64];
      a_end   <= ram_rdata[63:0];
    end
    if (st == S_CAP2) begin
      b_begin <= ram_rdata[127:64];
    end
    // Start of the next major cycle: now - ((now - origin) mod L) + L; origin when L is zero.
    if (st == S_DIVW) begin
      arr_base <= (cycle_len == 64'd0) ? origin :
                  cur.now_time - div_stat.rem + cycle_len;
    end
  end

  // Configuration and scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_len    <= 64'd1000000;
      origin       <= '0;
      slots_cfg    <= 4'd1;
      phase        <= PH_INACTIVE;
      client_count <= '0;
      cycle_base   <= '0;
      cursor       <= '0;
      win_start    <= '0;
      win_end      <= '0;
      budget       <= '0;
      used_slot    <= '0;
      used_total   <= '0;
      refill       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CYCLE_LEN: cycle_len <= cfg_data;
          REG_ORIGIN:    origin    <= cfg_data;
          REG_SLOTS:     slots_cfg <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      if (st == S_EXEC && out_free) begin
        phase        <= phase_next;
        client_count <= client_count_next;
        cycle_base   <= cycle_base_next;
        cursor       <= cursor_next;
        win_start    <= win_start_next;
        win_end      <= win_end_next;
        budget       <= budget_next;
        used_slot    <= used_slot_next;
        used_total   <= used_total_next;
        refill       <= refill_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (st == S_EXEC && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_EXEC && out_free) begin
      res.resv_state       <= phase_next;
      res.budget_left      <= budget_next;
      res.next_refill_time <= refill_next;
      res.consumed_in_slot <= used_slot_next;
      res.consumed_total   <= used_total_next;
      res.grant            <= grant;
      res.fault            <= fault;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    client_count <= CCW'(MAX_CLIENTS))
    else $error("client count above its limit");

  a_inactive_empty: assert property (@(posedge clk) disable iff (rst)
    phase == PH_INACTIVE |-> client_count == '0)
    else $error("clients present while the reservation is inactive");

  a_div_in_flight: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> st != S_IDLE && st != S_EXEC)
    else $error("remainder unit busy outside an event");

  a_fault_no_grant: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.fault |-> !res.grant)
    else $error("grant given on a faulting event");
`endif

endmodule

// File: hw/rtl/tdsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tdsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tdsr_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module tdsr_rem
  import tdsr_pkg::*;
#(
  parameter int W = TIME_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output div_stat_t    stat
);

  localparam int KW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  shf;
  logic [W-1:0]  dvs;
  logic [KW-1:0] count;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem, shf[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= KW'(W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == KW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      shf <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      shf <= {shf[W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[W-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.rem  = rem;

endmodule

// File: bench/table_driven_slot_reservation_tb.sv
// Self-checking testbench for the table-driven slot reservation scheduler.
`timescale 1ns / 1ps

module table_driven_slot_reservation_tb;
  import tdsr_pkg::*;

  // How a directed row is checked: by the predictor alone, or against a result
  // typed into the table that must come back from the reset state untouched.
  localparam int CHK_PREDICT = 0;
  localparam int CHK_ZERO_OK = 1;
  localparam int CHK_ZERO_FAULT = 2;

  // Register index that the scheduler does not decode; a write to it must be harmless.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        evt_valid;
  logic        evt_stall;
  evt_t        evt;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  table_driven_slot_reservation i_dut (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt      (evt),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Results that the scheduler still owes us, oldest first.
  res_t due_results[$];
  int   errors;

  // Idle control. In a burst stretch a side never idles; hold_req asks the
  // receiver to refuse results for a long stretch while items keep coming.
  bit sender_burst;
  bit receiver_burst;
  bit hold_req;

  // Our own copy of the configuration registers.
  logic [63:0] cf_len;
  logic [63:0] cf_origin;
  logic [3:0]  cf_slots;

  // Our own copy of the reservation state.
  logic [1:0]  sv_phase;
  int          sv_clients;
  logic [63:0] sv_base;
  int          sv_cursor;
  logic [63:0] sv_wstart;
  logic [63:0] sv_wend;
  logic [63:0] sv_budget;
  logic [63:0] sv_used_slot;
  logic [63:0] sv_used_total;
  logic [63:0] sv_refill;
  logic [63:0] sv_tab_begin[8];
  logic [63:0] sv_tab_end[8];

  // Weights of arrivals and departures in the current random phase, in percent.
  int arrive_pct;
  int depart_pct;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] time_left(logic [63:0] now);
    return (now >= sv_wend) ? 64'd0 : sv_wend - now;
  endfunction

  // Applies one event to the reservation copy and returns the result it causes.
  // An illegal event leaves every piece of state as it was.
  function automatic res_t reserve_step(evt_t e);
    res_t        r;
    logic [63:0] quo;
    int          span;
    int          c;
    bit          bad;
    bit          go;
    bad = 1'b0;
    go = 1'b0;
    case (e.func)
      FN_LOAD: begin
        sv_tab_begin[e.slot_number] = e.slot_begin;
        sv_tab_end[e.slot_number] = e.slot_finish;
      end
      FN_ARRIVE: begin
        if (sv_clients >= MAX_CLIENTS_DEF) begin
          bad = 1'b1;
        end else begin
          sv_clients++;
          if (sv_phase == PH_INACTIVE) begin
            // A zero cycle length gives a zero quotient and a zero product.
            quo = (cf_len != 0) ? (e.now_time - cf_origin) / cf_len : 64'd0;
            sv_base = cf_origin + (quo + 64'd1) * cf_len;
            sv_cursor = 0;
            sv_refill = sv_base + sv_tab_begin[0];
            sv_phase = PH_DEPLETED;
          end else if (sv_phase == PH_IDLE) begin
            sv_phase = PH_ACTIVE;
          end
        end
      end
      FN_DEPART: begin
        if (sv_phase == PH_INACTIVE || sv_phase == PH_IDLE || sv_clients == 0) begin
          bad = 1'b1;
        end else begin
          sv_clients--;
          if (sv_phase == PH_ACTIVE && sv_clients == 0) sv_phase = PH_IDLE;
        end
      end
      FN_REFILL: begin
        if (sv_phase == PH_INACTIVE) begin
          bad = 1'b1;
        end else begin
          c = sv_cursor % 8;
          sv_wstart = sv_base + sv_tab_begin[c];
          sv_wend = sv_base + sv_tab_end[c];
          sv_budget = time_left(e.now_time);
          sv_used_slot = 64'd0;
          // Slot counts of zero act as one, counts above the table as the table size.
          span = (cf_slots == 0) ? 1 : (cf_slots > 8) ? 8 : int'(cf_slots);
          sv_cursor = (c + 1) % span;
          if (sv_cursor == 0) sv_base = sv_base + cf_len;
          sv_refill = sv_base + sv_tab_begin[sv_cursor];
          sv_phase = (sv_clients != 0) ? PH_ACTIVE : PH_IDLE;
        end
      end
      FN_DRAIN: begin
        if (sv_phase == PH_INACTIVE || sv_phase == PH_DEPLETED || sv_wstart > e.now_time) begin
          bad = 1'b1;
        end else begin
          sv_used_slot = sv_used_slot + e.drain_amount;
          sv_used_total = sv_used_total + e.drain_amount;
          sv_budget = time_left(e.now_time);
          if (sv_budget == 0) sv_phase = PH_DEPLETED;
        end
      end
      FN_DISPATCH: begin
        if (sv_phase == PH_INACTIVE) begin
          bad = 1'b1;
        end else begin
          sv_budget = time_left(e.now_time);
          if (sv_budget == 0) sv_phase = PH_DEPLETED;
          else go = (sv_clients != 0);
        end
      end
      default: bad = 1'b1;
    endcase
    r.resv_state = sv_phase;
    r.budget_left = sv_budget;
    r.next_refill_time = sv_refill;
    r.consumed_in_slot = sv_used_slot;
    r.consumed_total = sv_used_total;
    r.grant = go;
    r.fault = bad;
    return r;
  endfunction

  // Offers one item and holds it until accepted, then queues what it should
  // cause and idles for a drawn number of cycles. The valid stays high when
  // no idling follows, so it is never lowered and raised in one step.
  task automatic post_event(evt_t e, int chk);
    res_t want;
    int   gap;
    evt <= e;
    evt_valid <= 1'b1;
    do @(posedge clk); while (evt_stall);
    want = reserve_step(e);
    if (chk != CHK_PREDICT) begin
      want = '0;
      want.fault = (chk == CHK_ZERO_FAULT);
    end
    due_results.push_back(want);
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes one register. The caller lowers the valid after its last write.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CYCLE_LEN: cf_len = val;
      REG_ORIGIN:    cf_origin = val;
      REG_SLOTS:     cf_slots = val[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    evt_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Registers change only while the scheduler is idle: every result is in and
  // a margin for a slow arrival has passed.
  task automatic set_schedule(logic [63:0] len, logic [63:0] origin, logic [63:0] slots);
    wait_drained();
    repeat (100) @(posedge clk);
    write_reg(REG_CYCLE_LEN, len);
    write_reg(REG_ORIGIN, origin);
    write_reg(REG_SLOTS, slots);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic evt_t make_row(logic [2:0] fn, logic [63:0] now, logic [2:0] sn,
                                    logic [63:0] b, logic [63:0] f, logic [63:0] d);
    evt_t e;
    e.func = fn;
    e.now_time = now;
    e.slot_number = sn;
    e.slot_begin = b;
    e.slot_finish = f;
    e.drain_amount = d;
    return e;
  endfunction

  // Random event. Times mostly land in or near the open window or the next
  // refill so that drains and dispatches get past their checks; the rest is
  // noise over the full range. Unused fields carry random bits as well.
  function automatic evt_t make_random();
    evt_t        e;
    int          pick;
    int          where;
    logic [63:0] span;
    e = make_row(3'($urandom), rand64(), 3'($urandom), rand64(), rand64(), rand64());
    pick = $urandom_range(0, 99);
    if (pick < 6) e.func = FN_LOAD;
    else if (pick < 6 + arrive_pct) e.func = FN_ARRIVE;
    else if (pick < 6 + arrive_pct + depart_pct) e.func = FN_DEPART;
    else if (pick < 6 + arrive_pct + depart_pct + 18) e.func = FN_REFILL;
    else if (pick < 6 + arrive_pct + depart_pct + 40) e.func = FN_DRAIN;
    else if (pick < 97) e.func = FN_DISPATCH;
    else e.func = 3'($urandom_range(6, 7));
    where = $urandom_range(0, 19);
    span = sv_wend - sv_wstart;
    if (span > 64'd2000) span = 64'd2000;
    if (where < 13) e.now_time = sv_wstart + $urandom_range(0, 32'(span) + 200);
    else if (where < 17) e.now_time = sv_refill + $urandom_range(0, 300);
    if (e.func == FN_LOAD && $urandom_range(0, 9) != 0) begin
      e.slot_begin = $urandom_range(0, 3000);
      e.slot_finish = e.slot_begin + $urandom_range(0, 1500);
    end
    if ($urandom_range(0, 7) != 0) e.drain_amount = $urandom_range(0, 500);
    return e;
  endfunction

  function automatic void report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Receiver: checks every accepted result against the oldest expectation and
  // then stalls for a drawn number of cycles. On request it refuses results
  // for a long stretch, counted here, so the scheduler backs up.
  initial begin
    int   stall_left;
    res_t want;
    stall_left = 0;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, res);
          errors++;
        end else begin
          want = due_results.pop_front();
          report_field("resv_state", 64'(want.resv_state), 64'(res.resv_state));
          report_field("budget_left", want.budget_left, res.budget_left);
          report_field("next_refill_time", want.next_refill_time, res.next_refill_time);
          report_field("consumed_in_slot", want.consumed_in_slot, res.consumed_in_slot);
          report_field("consumed_total", want.consumed_total, res.consumed_total);
          report_field("grant", 64'(want.grant), 64'(res.grant));
          report_field("fault", 64'(want.fault), 64'(res.fault));
        end
        stall_left = receiver_burst ? 0 : $urandom_range(0, 18);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        stall_left = 0;
      end
      res_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: too many cycles in a row without any handshake ends the run.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    evt_t dir_evt[$];
    int   dir_chk[$];
    int   n;
    errors = 0;
    hold_req = 1'b0;
    sender_burst = 1'b0;
    receiver_burst = 1'b0;
    arrive_pct = 20;
    depart_pct = 12;
    rst = 1'b1;
    evt_valid = 1'b0;
    evt = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CYCLE_LEN;
    cfg_data = '0;
    cf_len = 64'd1000000;
    cf_origin = 64'd0;
    cf_slots = 4'd1;
    sv_phase = PH_INACTIVE;
    sv_clients = 0;
    sv_base = '0;
    sv_cursor = 0;
    sv_wstart = '0;
    sv_wend = '0;
    sv_budget = '0;
    sv_used_slot = '0;
    sv_used_total = '0;
    sv_refill = '0;
    for (int i = 0; i < 8; i++) begin
      sv_tab_begin[i] = '0;
      sv_tab_end[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Straight out of reset every event but a load or an arrival
    // is illegal and nothing has moved, so those results are typed in. All eight
    // slots are loaded before the first arrival so the table is never read unwritten.
    dir_evt.push_back(make_row(3'd7, ALL_ONES, 3'd7, ALL_ONES, ALL_ONES, ALL_ONES));
    dir_chk.push_back(CHK_ZERO_FAULT);
    dir_evt.push_back(make_row(3'd6, 64'd0, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_chk.push_back(CHK_ZERO_FAULT);
    dir_evt.push_back(make_row(FN_REFILL, 64'd50, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_chk.push_back(CHK_ZERO_FAULT);
    dir_evt.push_back(make_row(FN_DEPART, 64'd50, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_chk.push_back(CHK_ZERO_FAULT);
    dir_evt.push_back(make_row(FN_DRAIN, 64'd50, 3'd0, 64'd0, 64'd0, ALL_ONES));
    dir_chk.push_back(CHK_ZERO_FAULT);
    dir_evt.push_back(make_row(FN_DISPATCH, 64'd50, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_chk.push_back(CHK_ZERO_FAULT);
    for (int s = 0; s < 7; s++) begin
      dir_evt.push_back(make_row(FN_LOAD, 64'd0, 3'(s), 64'(s * 100), 64'(s * 100 + 80), 64'd0));
      dir_chk.push_back(CHK_ZERO_OK);
    end
    dir_evt.push_back(make_row(FN_LOAD, ALL_ONES, 3'd7, ALL_ONES, ALL_ONES, 64'd0));
    dir_chk.push_back(CHK_ZERO_OK);
    // First arrival finds the next cycle start; then a drain while depleted
    // faults, a refill opens slot zero and the usual traffic follows.
    dir_evt.push_back(make_row(FN_ARRIVE, 64'd1234567, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_ARRIVE, 64'd1234600, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_DRAIN, 64'd2000010, 3'd0, 64'd0, 64'd0, 64'd5));
    dir_evt.push_back(make_row(FN_REFILL, 64'd2000000, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_DISPATCH, 64'd2000030, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_DRAIN, 64'd2000040, 3'd0, 64'd0, 64'd0, ALL_ONES));
    dir_evt.push_back(make_row(FN_DEPART, 64'd2000050, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_DEPART, 64'd2000060, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_DEPART, 64'd2000070, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_ARRIVE, 64'd2000075, 3'd0, 64'd0, 64'd0, 64'd0));
    dir_evt.push_back(make_row(FN_DISPATCH, ALL_ONES, 3'd0, 64'd0, 64'd0, 64'd0));
    while (dir_chk.size() < dir_evt.size()) dir_chk.push_back(CHK_PREDICT);
    foreach (dir_evt[i]) post_event(dir_evt[i], dir_chk[i]);

    // Random phases, each under its own schedule setting, extremes included.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_schedule(64'd1000, 64'd0, 64'd1);
        1: set_schedule(64'd0, ALL_ONES, 64'd0);
        2: set_schedule(ALL_ONES, rand64(), 64'd15);
        3: begin
          set_schedule(64'd1, 64'd5, 64'd8);
          write_reg(REG_UNUSED, rand64());
          cfg_valid <= 1'b0;
          @(posedge clk);
        end
        4: set_schedule(64'd5000, 64'd123, 64'hFFFF_0000_0000_0003);
        default: set_schedule($urandom_range(1, 100000), rand64(), $urandom_range(0, 15));
      endcase
      // Some phases lean on arrivals to reach the client limit.
      arrive_pct = (ph % 2 == 0) ? 30 : 14;
      depart_pct = (ph % 2 == 0) ? 6 : 14;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          sender_burst = ($urandom_range(0, 3) == 0);
          receiver_burst = ($urandom_range(0, 3) == 0);
        end
        if (ph == 1 && n == 60) hold_req = 1'b1;
        if (ph == 3 && n == 75) wait_drained();
        post_event(make_random(), CHK_PREDICT);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tdsr_pkg.sv
hw/rtl/tdsr_ram.sv
hw/rtl/tdsr_rem.sv
hw/rtl/table_driven_slot_reservation.sv
bench/table_driven_slot_reservation_tb.sv
